FILE: sv/circular_double_ended_queue_macros.svh
// Assertion macros for the checker file of the double-ended queue.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define CDQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("double-ended queue assertion failed");

// Next-cycle implication, ignored while reset is high.
`define CDQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("double-ended queue assertion failed");

// Next-cycle implication that is checked through reset as well.
`define CDQ_ASSERT_RESET(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("double-ended queue assertion failed after reset");

`endif

FILE: sv/cdq_pkg.sv
// Types, codes and constants shared by the double-ended queue modules.
package cdq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Command queue between the front and the back; depth is a power of two.
   localparam int CMD_DEPTH = 2;
   localparam int CMD_AW    = $clog2(CMD_DEPTH);
   localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

   // Result queue at the output; depth is a power of two.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_AW    = $clog2(RSP_DEPTH);
   localparam int RSP_CW    = $clog2(RSP_DEPTH + 1);

   typedef enum logic [2:0] {
      FUNC_PUSH_REAR    = 3'd0,
      FUNC_POP_FRONT    = 3'd1,
      FUNC_LIST_FORWARD = 3'd2,
      FUNC_PUSH_FRONT   = 3'd3,
      FUNC_POP_REAR     = 3'd4,
      FUNC_LIST_REVERSE = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      OP_PUSH_REAR,
      OP_PUSH_FRONT,
      OP_POP_FRONT,
      OP_POP_REAR,
      OP_LIST_FORWARD,
      OP_LIST_REVERSE
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_LIST
   } back_state_type;

   typedef struct packed {
      logic [2:0]          func;
      logic signed [31:0]  value_in;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0]  value_out;
      status_type          status;
      logic                last;
   } rsp_word_type;

   typedef struct packed {
      op_type              op;
      logic [31:0]         value;
   } cmd_type;

endpackage

FILE: sv/cdq_front.sv
// Front end: accepts request words, decodes the function code and queues commands.
module cdq_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  cdq_pkg::req_word_type req_word,
   output logic                  cmd_valid,
   output cdq_pkg::cmd_type      cmd,
   input  logic                  cmd_take
);

   cdq_pkg::cmd_type             slots_ff [cdq_pkg::CMD_DEPTH];
   logic [cdq_pkg::CMD_AW-1:0]   wr_idx_ff, wr_idx_in;
   logic [cdq_pkg::CMD_AW-1:0]   rd_idx_ff, rd_idx_in;
   logic [cdq_pkg::CMD_CW-1:0]   count_ff, count_in;
   logic                         code_ok;
   logic                         store;
   cdq_pkg::op_type              op;

   always_comb begin
      code_ok = 1'b1;
      op      = cdq_pkg::OP_PUSH_REAR;
      unique case (req_word.func)
         cdq_pkg::FUNC_PUSH_REAR:    op = cdq_pkg::OP_PUSH_REAR;
         cdq_pkg::FUNC_POP_FRONT:    op = cdq_pkg::OP_POP_FRONT;
         cdq_pkg::FUNC_LIST_FORWARD: op = cdq_pkg::OP_LIST_FORWARD;
         cdq_pkg::FUNC_PUSH_FRONT:   op = cdq_pkg::OP_PUSH_FRONT;
         cdq_pkg::FUNC_POP_REAR:     op = cdq_pkg::OP_POP_REAR;
         cdq_pkg::FUNC_LIST_REVERSE: op = cdq_pkg::OP_LIST_REVERSE;
         default:                    code_ok = 1'b0;
      endcase
   end

   assign full      = (count_ff == cdq_pkg::CMD_CW'(cdq_pkg::CMD_DEPTH));
   assign store     = push && !full && code_ok;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = slots_ff[rd_idx_ff];

   always_comb begin
      wr_idx_in = store ? wr_idx_ff + 1'b1 : wr_idx_ff;
      rd_idx_in = cmd_take ? rd_idx_ff + 1'b1 : rd_idx_ff;
      count_in  = count_ff + cdq_pkg::CMD_CW'(store) - cdq_pkg::CMD_CW'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         slots_ff[wr_idx_ff] <= '{op: op, value: req_word.value_in};
      end
   end

endmodule

FILE: sv/cdq_back.sv
// Back end: ring buffer memory, head and tail indexes, and the listing sequencer.
module cdq_back #(
   parameter int DEPTH      = cdq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   input  cdq_pkg::cmd_type           cmd,
   output logic                       cmd_take,
   input  logic [cdq_pkg::RSP_CW-1:0] rsp_count,
   output logic                       rsp_valid,
   output cdq_pkg::rsp_word_type      rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int UW = cdq_pkg::RSP_CW + 1;

   logic [DATA_WIDTH-1:0]       entry_ff [DEPTH];
   logic [DATA_WIDTH-1:0]       rd_data_ff;

   cdq_pkg::back_state_type     state_ff, state_in;
   logic [AW-1:0]               head_ff, head_in;
   logic [AW-1:0]               tail_ff, tail_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [AW-1:0]               ptr_ff, ptr_in;
   logic [CW-1:0]               remain_ff, remain_in;
   logic                        reverse_ff, reverse_in;
   logic                        stage_valid_ff, stage_valid_in;
   logic                        stage_read_ff, stage_read_in;
   cdq_pkg::status_type         stage_status_ff, stage_status_in;
   logic                        stage_last_ff, stage_last_in;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [DATA_WIDTH-1:0]       wr_data;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [UW-1:0]               used;
   logic                        can_emit;
   logic                        is_full;
   logic                        is_empty;
   logic [AW-1:0]               head_dec;
   logic [AW-1:0]               tail_dec;
   logic [63:0]                 value_wide;
   logic signed [63:0]          ext_wide;

   function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] idx);
      return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] idx);
      return (idx == '0) ? AW'(DEPTH - 1) : idx - 1'b1;
   endfunction

   assign used       = {1'b0, rsp_count} + UW'(stage_valid_ff);
   assign can_emit   = (used < UW'(cdq_pkg::RSP_DEPTH));
   assign is_full    = (count_ff == CW'(DEPTH));
   assign is_empty   = (count_ff == '0);
   assign head_dec   = ring_dec(head_ff);
   assign tail_dec   = ring_dec(tail_ff);
   assign value_wide = {32'b0, cmd.value};
   assign wr_data    = value_wide[DATA_WIDTH-1:0];

   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      ptr_in          = ptr_ff;
      remain_in       = remain_ff;
      reverse_in      = reverse_ff;
      stage_valid_in  = 1'b0;
      stage_read_in   = 1'b0;
      stage_status_in = cdq_pkg::STATUS_OK;
      stage_last_in   = 1'b1;
      wr_en           = 1'b0;
      wr_addr         = tail_ff;
      rd_en           = 1'b0;
      rd_addr         = head_ff;
      cmd_take        = 1'b0;
      unique case (state_ff)
         cdq_pkg::BACK_IDLE: begin
            if (cmd_valid && can_emit) begin
               cmd_take = 1'b1;
               unique case (cmd.op)
                  cdq_pkg::OP_PUSH_REAR: begin
                     stage_valid_in = 1'b1;
                     if (is_full) begin
                        stage_status_in = cdq_pkg::STATUS_OVERFLOW;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = tail_ff;
                        tail_in  = ring_inc(tail_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  cdq_pkg::OP_PUSH_FRONT: begin
                     stage_valid_in = 1'b1;
                     if (is_full) begin
                        stage_status_in = cdq_pkg::STATUS_OVERFLOW;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = head_dec;
                        head_in  = head_dec;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  cdq_pkg::OP_POP_FRONT: begin
                     stage_valid_in = 1'b1;
                     if (is_empty) begin
                        stage_status_in = cdq_pkg::STATUS_UNDERFLOW;
                     end else begin
                        rd_en         = 1'b1;
                        rd_addr       = head_ff;
                        head_in       = ring_inc(head_ff);
                        count_in      = count_ff - 1'b1;
                        stage_read_in = 1'b1;
                     end
                  end
                  cdq_pkg::OP_POP_REAR: begin
                     stage_valid_in = 1'b1;
                     if (is_empty) begin
                        stage_status_in = cdq_pkg::STATUS_UNDERFLOW;
                     end else begin
                        rd_en         = 1'b1;
                        rd_addr       = tail_dec;
                        tail_in       = tail_dec;
                        count_in      = count_ff - 1'b1;
                        stage_read_in = 1'b1;
                     end
                  end
                  cdq_pkg::OP_LIST_FORWARD, cdq_pkg::OP_LIST_REVERSE: begin
                     if (is_empty) begin
                        stage_valid_in  = 1'b1;
                        stage_status_in = cdq_pkg::STATUS_EMPTY;
                     end else begin
                        state_in   = cdq_pkg::BACK_LIST;
                        reverse_in = (cmd.op == cdq_pkg::OP_LIST_REVERSE);
                        ptr_in     = (cmd.op == cdq_pkg::OP_LIST_REVERSE) ? tail_dec : head_ff;
                        remain_in  = count_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         cdq_pkg::BACK_LIST: begin
            if (can_emit) begin
               rd_en          = 1'b1;
               rd_addr        = ptr_ff;
               stage_valid_in = 1'b1;
               stage_read_in  = 1'b1;
               stage_last_in  = (remain_ff == CW'(1));
               ptr_in         = reverse_ff ? ring_dec(ptr_ff) : ring_inc(ptr_ff);
               remain_in      = remain_ff - 1'b1;
               if (remain_ff == CW'(1)) begin
                  state_in = cdq_pkg::BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = cdq_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= cdq_pkg::BACK_IDLE;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff          <= ptr_in;
      remain_ff       <= remain_in;
      reverse_ff      <= reverse_in;
      stage_read_ff   <= stage_read_in;
      stage_status_ff <= stage_status_in;
      stage_last_ff   <= stage_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_ff[rd_addr];
      end
   end

   assign ext_wide = 64'($signed(rd_data_ff));

   always_comb begin
      rsp_valid          = stage_valid_ff;
      rsp_data.value_out = stage_read_ff ? ext_wide[31:0] : '0;
      rsp_data.status    = stage_status_ff;
      rsp_data.last      = stage_last_ff;
   end

endmodule

FILE: sv/cdq_rsp_queue.sv
// Result queue that holds finished response words until they are popped.
module cdq_rsp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_valid,
   input  cdq_pkg::rsp_word_type      wr_word,
   input  logic                       pop,
   output logic                       empty,
   output cdq_pkg::rsp_word_type      rsp_word,
   output logic [cdq_pkg::RSP_CW-1:0] count
);

   cdq_pkg::rsp_word_type        slots_ff [cdq_pkg::RSP_DEPTH];
   logic [cdq_pkg::RSP_AW-1:0]   wr_idx_ff, wr_idx_in;
   logic [cdq_pkg::RSP_AW-1:0]   rd_idx_ff, rd_idx_in;
   logic [cdq_pkg::RSP_CW-1:0]   count_ff, count_in;
   logic                         take;

   assign empty    = (count_ff == '0);
   assign take     = pop && !empty;
   assign rsp_word = slots_ff[rd_idx_ff];
   assign count    = count_ff;

   always_comb begin
      wr_idx_in = wr_valid ? wr_idx_ff + 1'b1 : wr_idx_ff;
      rd_idx_in = take ? rd_idx_ff + 1'b1 : rd_idx_ff;
      count_in  = count_ff + cdq_pkg::RSP_CW'(wr_valid) - cdq_pkg::RSP_CW'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         slots_ff[wr_idx_ff] <= wr_word;
      end
   end

endmodule

FILE: sv/circular_double_ended_queue.sv
// Double-ended queue on a ring buffer of DEPTH entries, with push, pop and
// listing from either end. A push or a pop gives one response word. A listing
// first loads its pointer and entry count, then reads one entry of the
// single-port memory each cycle while the response queue has room, and an
// empty listing gives one word with status EMPTY. The back end takes a queued
// request word only while the response queue has room; its first response word
// goes through the stage registers and then the response queue to the response
// ports. A small response queue lets requests keep flowing while responses wait
// to be popped. Entries need no clearing after reset.
module circular_double_ended_queue #(
   parameter int DEPTH      = cdq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  cdq_pkg::req_word_type req_word,
   output logic                  empty,
   input  logic                  pop,
   output cdq_pkg::rsp_word_type rsp_word
);

   logic                        cmd_valid;
   cdq_pkg::cmd_type            cmd;
   logic                        cmd_take;
   logic [cdq_pkg::RSP_CW-1:0]  rsp_count;
   logic                        rsp_valid;
   cdq_pkg::rsp_word_type       rsp_data;

   cdq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   cdq_back #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_count (rsp_count),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   cdq_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (rsp_valid),
      .wr_word  (rsp_data),
      .pop      (pop),
      .empty    (empty),
      .rsp_word (rsp_word),
      .count    (rsp_count)
   );

endmodule

FILE: sv/cdq_checker.sv
// Port-level checks for the double-ended queue and their binding to the top level.
`include "circular_double_ended_queue_macros.svh"

module cdq_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  full,
   input logic                  empty,
   input logic                  pop,
   input cdq_pkg::rsp_word_type rsp_word
);

   logic rsp_error;

   assign rsp_error = !empty && (rsp_word.status != cdq_pkg::STATUS_OK);

   `CDQ_ASSERT_RESET(a_reset_idle, reset, empty && !full)
   `CDQ_ASSERT_NOW(a_error_no_value, rsp_error, rsp_word.value_out == 0)
   `CDQ_ASSERT_NOW(a_error_is_last, rsp_error, rsp_word.last)
   `CDQ_ASSERT_NEXT(a_word_holds, !empty && !pop, !empty && $stable(rsp_word))

endmodule

bind circular_double_ended_queue cdq_checker u_checker (.*);
